@@ hw/rtl/abg_pkg.sv @@
// Shared types, constants and register indexes of the anchor box generator.
`timescale 1ns / 1ps
`default_nettype none

package abg_pkg;

  // Default sizes of the dimension table and of the feature-map grid.
  localparam int MAX_BOXES_DEF = 8;
  localparam int GRID_SIZE_DEF = 256;

  // Depth of the command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Stream widths, packed fields rounded up to whole bytes.
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 152;
  localparam int COORD_W    = 18;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_IMG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_IMG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOXES_PER_CELL = 3'd6;

  // Register reset values.
  localparam logic [7:0]  RST_CELL_OFFSET    = 8'd128;
  localparam logic [15:0] RST_STEP           = 16'd2048;
  localparam logic [23:0] RST_INV_IMG        = 24'd55924;
  localparam logic [3:0]  RST_BOXES_PER_CELL = 4'd1;

  // Input operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CELL = 1'b1;

  typedef struct packed {
    logic [7:0]  cell_offset;
    logic [15:0] step_x;
    logic [15:0] step_y;
    logic [23:0] inv_width;
    logic [23:0] inv_height;
    logic        clip_enable;
    logic [3:0]  boxes_per_cell;
  } abg_cfg_t;

  // One queued command: either a table load or a cell with its pixel centre.
  typedef struct packed {
    logic        is_load;
    logic [2:0]  slot;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [3:0]  num_boxes;
  } abg_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } abg_state_e;

endpackage

`default_nettype wire

@@ hw/rtl/abg_front.sv @@
// Front end: takes input items, classifies them and computes the cell centre.
`timescale 1ns / 1ps
`default_nettype none

module abg_front import abg_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF,
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire abg_cfg_t             cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 in_op_i,
  input  wire logic [IN_DATA_W-1:0] in_data_i,
  output logic                      push_valid_o,
  input  wire logic                 push_ready_i,
  output abg_cmd_t                  push_cmd_o
);

  logic        fv_q;
  logic        op_q;
  logic [7:0]  col_q;
  logic [7:0]  row_q;
  logic [2:0]  slot_q;
  logic [15:0] w_q;
  logic [15:0] h_q;

  logic        on_grid;
  logic [3:0]  n_sat;
  logic        emit;
  logic        consume;

  always_comb begin
    on_grid = (32'(col_q) < GRID_SIZE) && (32'(row_q) < GRID_SIZE);
    n_sat   = (32'(cfg_i.boxes_per_cell) > MAX_BOXES) ? 4'(MAX_BOXES)
                                                      : cfg_i.boxes_per_cell;
    // Cells off the grid or with no boxes to emit are dropped here.
    emit         = (op_q == OP_LOAD) || (on_grid && (n_sat != 4'd0));
    push_valid_o = fv_q && emit;
    consume      = fv_q && (!emit || push_ready_i);
    in_ready_o   = !fv_q || consume;

    push_cmd_o.is_load   = (op_q == OP_LOAD);
    push_cmd_o.slot      = slot_q;
    push_cmd_o.box_w     = w_q;
    push_cmd_o.box_h     = h_q;
    push_cmd_o.cx        = {col_q, cfg_i.cell_offset} * cfg_i.step_x;
    push_cmd_o.cy        = {row_q, cfg_i.cell_offset} * cfg_i.step_y;
    push_cmd_o.num_boxes = n_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (in_ready_o) begin
      fv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= in_op_i;
      col_q  <= in_data_i[7:0];
      row_q  <= in_data_i[15:8];
      slot_q <= in_data_i[18:16];
      w_q    <= in_data_i[34:19];
      h_q    <= in_data_i[50:35];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/abg_queue.sv @@
// Short command queue between the front end and the box generation back end.
`timescale 1ns / 1ps
`default_nettype none

module abg_queue import abg_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_valid_i,
  output logic          push_ready_o,
  input  wire abg_cmd_t push_cmd_i,
  output logic          head_valid_o,
  output abg_cmd_t      head_cmd_o,
  input  wire logic     pop_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  abg_cmd_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
    head_valid_o = (cnt_q != '0);
    head_cmd_o   = mem_q[rd_ptr_q];
    do_push      = push_valid_i && push_ready_o;
    do_pop       = pop_i && head_valid_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= PTR_W'((32'(wr_ptr_q) + 1) % QUEUE_DEPTH);
      end
      if (do_pop) begin
        rd_ptr_q <= PTR_W'((32'(rd_ptr_q) + 1) % QUEUE_DEPTH);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/abg_back.sv @@
// Back end: holds the dimension table; makes one box per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module abg_back import abg_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire abg_cfg_t              cfg_i,
  input  wire logic                  q_valid_i,
  input  wire abg_cmd_t              q_cmd_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0]      out_data_o,
  output logic                       out_last_o
);

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  // Rounds a Q.40 product to Q.16 half up, then clamps or saturates.
  function automatic logic signed [COORD_W-1:0] corner_fn(
    input logic signed [58:0] prod,
    input logic               clip
  );
    logic signed [58:0] rnd;
    logic signed [34:0] v;
    logic signed [COORD_W-1:0] res;
    rnd = prod + 59'sd8388608;
    v   = rnd[58:24];
    if (clip) begin
      if (v < 35'sd0) begin
        res = '0;
      end else if (v > 35'sd65536) begin
        res = 18'sd65536;
      end else begin
        res = v[COORD_W-1:0];
      end
    end else begin
      if (v > 35'sd131071) begin
        res = 18'sd131071;
      end else if (v < -35'sd131072) begin
        res = -18'sd131072;
      end else begin
        res = v[COORD_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_fn(input logic signed [18:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > 19'sd131071) begin
      res = 18'sd131071;
    end else if (v < -19'sd131072) begin
      res = -18'sd131072;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

  logic [31:0] dim_mem [MAX_BOXES];

  abg_state_e  state_q, state_d;
  logic [3:0]  k_q, k_d;
  logic [31:0] cx_q, cy_q;
  logic [3:0]  n_q;

  logic        en;
  logic        issue_v;
  logic [3:0]  issue_k;
  logic [31:0] issue_cx, issue_cy;
  logic        issue_last;
  logic        tbl_we;
  logic        take_cell;

  // Stage 1: table entry read.
  logic        v1_q, last1_q;
  logic [2:0]  k1_q;
  logic [31:0] cx1_q, cy1_q, dim1_q;
  // Stage 2: corners in pixels, Q16.16 signed.
  logic        v2_q, last2_q;
  logic [2:0]  k2_q;
  logic signed [33:0] px0_q, px1_q, py0_q, py1_q;
  // Stage 3: products with the reciprocals.
  logic        v3_q, last3_q;
  logic [2:0]  k3_q;
  logic signed [58:0] mx0_q, mx1_q, my0_q, my1_q;
  // Stage 4: normalized corners.
  logic        v4_q, last4_q;
  logic [2:0]  k4_q;
  logic signed [COORD_W-1:0] x0_q, x1_q, y0_q, y1_q;
  // Output register.
  logic        ov_q;

  logic signed [18:0] sum_x, sum_y, dif_x, dif_y;

  assign en = !ov_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    issue_v    = 1'b0;
    issue_k    = k_q;
    issue_cx   = cx_q;
    issue_cy   = cy_q;
    issue_last = 1'b0;
    q_pop_o    = 1'b0;
    tbl_we     = 1'b0;
    take_cell  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && en) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.is_load) begin
            tbl_we = (32'(q_cmd_i.slot) < MAX_BOXES);
          end else begin
            take_cell  = 1'b1;
            issue_v    = 1'b1;
            issue_k    = 4'd0;
            issue_cx   = q_cmd_i.cx;
            issue_cy   = q_cmd_i.cy;
            issue_last = (q_cmd_i.num_boxes == 4'd1);
            if (q_cmd_i.num_boxes != 4'd1) begin
              state_d = ST_RUN;
              k_d     = 4'd1;
            end
          end
        end
      end
      ST_RUN: begin
        if (en) begin
          issue_v    = 1'b1;
          issue_last = (k_q == n_q - 4'd1);
          if (issue_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (en) begin
        v1_q <= issue_v;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        ov_q <= v4_q;
      end
    end
  end

  // Table and the current cell; the table is never cleared.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      dim_mem[IDX_W'(q_cmd_i.slot)] <= {q_cmd_i.box_h, q_cmd_i.box_w};
    end
    if (take_cell) begin
      cx_q <= q_cmd_i.cx;
      cy_q <= q_cmd_i.cy;
      n_q  <= q_cmd_i.num_boxes;
    end
    if (en) begin
      dim1_q <= dim_mem[IDX_W'(issue_k)];
    end
  end

  always_comb begin
    sum_x = 19'(x0_q) + 19'(x1_q);
    sum_y = 19'(y0_q) + 19'(y1_q);
    dif_x = 19'(x1_q) - 19'(x0_q);
    dif_y = 19'(y1_q) - 19'(y0_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_q    <= issue_k[2:0];
      last1_q <= issue_last;
      cx1_q   <= issue_cx;
      cy1_q   <= issue_cy;

      k2_q    <= k1_q;
      last2_q <= last1_q;
      px0_q   <= $signed({2'b00, cx1_q}) - $signed({7'd0, dim1_q[15:0], 11'd0});
      px1_q   <= $signed({2'b00, cx1_q}) + $signed({7'd0, dim1_q[15:0], 11'd0});
      py0_q   <= $signed({2'b00, cy1_q}) - $signed({7'd0, dim1_q[31:16], 11'd0});
      py1_q   <= $signed({2'b00, cy1_q}) + $signed({7'd0, dim1_q[31:16], 11'd0});

      k3_q    <= k2_q;
      last3_q <= last2_q;
      mx0_q   <= px0_q * $signed({1'b0, cfg_i.inv_width});
      mx1_q   <= px1_q * $signed({1'b0, cfg_i.inv_width});
      my0_q   <= py0_q * $signed({1'b0, cfg_i.inv_height});
      my1_q   <= py1_q * $signed({1'b0, cfg_i.inv_height});

      k4_q    <= k3_q;
      last4_q <= last3_q;
      x0_q    <= corner_fn(mx0_q, cfg_i.clip_enable);
      x1_q    <= corner_fn(mx1_q, cfg_i.clip_enable);
      y0_q    <= corner_fn(my0_q, cfg_i.clip_enable);
      y1_q    <= corner_fn(my1_q, cfg_i.clip_enable);

      out_last_o <= last4_q;
      out_data_o <= {5'd0,
                     sat_fn(dif_y), sat_fn(dif_x),
                     sum_y[18:1], sum_x[18:1],
                     y1_q, x1_q, y0_q, x0_q,
                     k4_q};
    end
  end

  assign out_valid_o = ov_q;

endmodule

`default_nettype wire

@@ hw/rtl/anchor_box_generator_core.sv @@
// Top level of the anchor box generator: stream ports, registers and the two halves.
`timescale 1ns / 1ps
`default_nettype none

// A cell item passes the front end register, the queue, the back end stages and
// the output register to its first box, when the queue is empty and the output is free.
// The back end pipeline gives one box per cycle while the output is not stalled;
// a load takes its turn there without a box, and a dropped cell never gets there.
// Reset clears the registers to their defaults, empties the queue and the pipeline;
// the dimension table is not cleared and must be loaded before use.

module anchor_box_generator_core import abg_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF,
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  // Configuration write channel.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,

  // Input items.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0 up: column[7:0], row[15:8], entry_slot[18:16],
  // box_width[34:19], box_height[50:35], zero fill [55:51].
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Field: operation[0].
  input  wire logic                  s_axis_tuser,

  // Result items, one per box.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // Fields from bit 0 up: box_index[2:0], x_min[20:3], y_min[38:21],
  // x_max[56:39], y_max[74:57], x_center[92:75], y_center[110:93],
  // norm_width[128:111], norm_height[146:129], zero fill [151:147].
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // Set on the final box of a cell.
  output logic                       m_axis_tlast
);

  abg_cfg_t cfg_q;

  logic     push_valid;
  logic     push_ready;
  abg_cmd_t push_cmd;
  logic     head_valid;
  abg_cmd_t head_cmd;
  logic     pop;

  // Registers are always writable; software must write them only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_offset    <= RST_CELL_OFFSET;
      cfg_q.step_x         <= RST_STEP;
      cfg_q.step_y         <= RST_STEP;
      cfg_q.inv_width      <= RST_INV_IMG;
      cfg_q.inv_height     <= RST_INV_IMG;
      cfg_q.clip_enable    <= 1'b0;
      cfg_q.boxes_per_cell <= RST_BOXES_PER_CELL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CELL_OFFSET:    cfg_q.cell_offset    <= cfg_data_i[7:0];
        CFG_STEP_X:         cfg_q.step_x         <= cfg_data_i[15:0];
        CFG_STEP_Y:         cfg_q.step_y         <= cfg_data_i[15:0];
        CFG_INV_IMG_WIDTH:  cfg_q.inv_width      <= cfg_data_i;
        CFG_INV_IMG_HEIGHT: cfg_q.inv_height     <= cfg_data_i;
        CFG_CLIP_ENABLE:    cfg_q.clip_enable    <= cfg_data_i[0];
        CFG_BOXES_PER_CELL: cfg_q.boxes_per_cell <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // The front end registers each item, drops cells that produce nothing and
  // computes the pixel center of the cell before queueing it.
  abg_front #(
    .MAX_BOXES (MAX_BOXES),
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // Loads and cells stay in order in the queue, so a load always lands in the
  // table before any later cell reads it.
  abg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  // The back end walks the table entries of one cell at a time and stalls as
  // a whole while its output register waits to be taken.
  abg_back #(
    .MAX_BOXES (MAX_BOXES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (head_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ tb/tb_anchor_box_generator_core.sv @@
// Self-checking testbench of the anchor box generator core with directed and random items.
`timescale 1ns / 1ps

module tb_anchor_box_generator_core;
  import abg_pkg::*;

  localparam int CLK_HALF          = 4;
  localparam int RESET_CYCLES      = 4;
  localparam int RANDOM_PHASES     = 8;
  localparam int ITEMS_PER_PHASE   = 60;
  // Loads and dropped cells give no box, so the block may still be busy after the last box.
  localparam int DRAIN_CYCLES      = 32;
  localparam int LONG_STALL_CYCLES = 150;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int PRINT_LIMIT       = 40;
  // Phase with the long receiver hold-off; the last phase runs without idling.
  localparam int STALL_PHASE       = 3;

  localparam longint Q_ONE      = 65536;
  localparam longint Q_MAX      = 131071;
  localparam longint Q_MIN      = -131072;
  localparam longint ROUND_HALF = 64'sd8388608;

  typedef struct {
    logic        op;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [2:0]  slot;
    logic [15:0] box_w;
    logic [15:0] box_h;
  } grid_item_t;

  typedef struct {
    logic [2:0]         index;
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_max;
    logic [COORD_W-1:0] x_center;
    logic [COORD_W-1:0] y_center;
    logic [COORD_W-1:0] norm_w;
    logic [COORD_W-1:0] norm_h;
    logic               last;
  } anchor_box_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Shadow of the registers and of the dimension table.
  abg_cfg_t    shadow_cfg;
  logic [15:0] dim_w [MAX_BOXES_DEF];
  logic [15:0] dim_h [MAX_BOXES_DEF];

  grid_item_t  pending_items[$];
  grid_item_t  offered_item;
  anchor_box_t expected_boxes[$];

  int items_queued   = 0;
  int items_taken    = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  int stall_left     = 0;
  bit long_stall_armed = 1'b0;
  bit long_stall_done  = 1'b0;
  bit no_idle          = 1'b0;

  always #CLK_HALF clk_i = ~clk_i;

  anchor_box_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Pixel corner in Q16.16 times a Q0.24 reciprocal, rounded half up to Q.16,
  // then clipped to the unit range or saturated to 18 bits.
  function automatic longint scale_corner(longint pix, logic [23:0] inv);
    longint v;
    v = (pix * longint'(inv) + ROUND_HALF) >>> 24;
    if (shadow_cfg.clip_enable) begin
      if (v < 0) v = 0;
      else if (v > Q_ONE) v = Q_ONE;
    end else begin
      v = clamp_q(v);
    end
    return v;
  endfunction

  // Updates the table shadow for a load, or queues the boxes a cell yields.
  function automatic void predict_anchor_boxes(grid_item_t it);
    longint      cx, cy, hw, hh, x0, y0, x1, y1, mid_x, mid_y, span_x, span_y;
    int          n;
    anchor_box_t b;
    if (it.op == OP_LOAD) begin
      dim_w[it.slot] = it.box_w;
      dim_h[it.slot] = it.box_h;
      return;
    end
    n = (shadow_cfg.boxes_per_cell > MAX_BOXES_DEF) ? MAX_BOXES_DEF
                                                    : shadow_cfg.boxes_per_cell;
    cx = longint'({it.column, shadow_cfg.cell_offset}) * longint'(shadow_cfg.step_x);
    cy = longint'({it.row, shadow_cfg.cell_offset}) * longint'(shadow_cfg.step_y);
    for (int k = 0; k < n; k++) begin
      hw = longint'(dim_w[k]) << 11;
      hh = longint'(dim_h[k]) << 11;
      x0 = scale_corner(cx - hw, shadow_cfg.inv_width);
      y0 = scale_corner(cy - hh, shadow_cfg.inv_height);
      x1 = scale_corner(cx + hw, shadow_cfg.inv_width);
      y1 = scale_corner(cy + hh, shadow_cfg.inv_height);
      // Center is the floor of the corner mean; size saturates like a corner.
      mid_x  = (x0 + x1) >>> 1;
      mid_y  = (y0 + y1) >>> 1;
      span_x = clamp_q(x1 - x0);
      span_y = clamp_q(y1 - y0);
      b.index    = 3'(k);
      b.x_min    = x0[COORD_W-1:0];
      b.y_min    = y0[COORD_W-1:0];
      b.x_max    = x1[COORD_W-1:0];
      b.y_max    = y1[COORD_W-1:0];
      b.x_center = mid_x[COORD_W-1:0];
      b.y_center = mid_y[COORD_W-1:0];
      b.norm_w   = span_x[COORD_W-1:0];
      b.norm_h   = span_y[COORD_W-1:0];
      b.last     = (k == n - 1);
      expected_boxes = {expected_boxes, b};
    end
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_CELL_OFFSET:    shadow_cfg.cell_offset    = val[7:0];
      CFG_STEP_X:         shadow_cfg.step_x         = val[15:0];
      CFG_STEP_Y:         shadow_cfg.step_y         = val[15:0];
      CFG_INV_IMG_WIDTH:  shadow_cfg.inv_width      = val[23:0];
      CFG_INV_IMG_HEIGHT: shadow_cfg.inv_height     = val[23:0];
      CFG_CLIP_ENABLE:    shadow_cfg.clip_enable    = val[0];
      CFG_BOXES_PER_CELL: shadow_cfg.boxes_per_cell = val[3:0];
      default: ;
    endcase
  endfunction

  // Valid stays high across back-to-back writes; the caller lowers it once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  task automatic program_config(input abg_cfg_t c);
    write_reg(CFG_CELL_OFFSET,    CFG_DATA_W'(c.cell_offset));
    write_reg(CFG_STEP_X,         CFG_DATA_W'(c.step_x));
    write_reg(CFG_STEP_Y,         CFG_DATA_W'(c.step_y));
    write_reg(CFG_INV_IMG_WIDTH,  CFG_DATA_W'(c.inv_width));
    write_reg(CFG_INV_IMG_HEIGHT, CFG_DATA_W'(c.inv_height));
    write_reg(CFG_CLIP_ENABLE,    CFG_DATA_W'(c.clip_enable));
    write_reg(CFG_BOXES_PER_CELL, CFG_DATA_W'(c.boxes_per_cell));
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every item is taken and every box has come, then lets the
  // block finish any trailing loads before the registers change.
  task automatic wait_for_drain();
    while (items_taken != items_queued || expected_boxes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_load(input logic [2:0] slot, input logic [15:0] w, input logic [15:0] h);
    grid_item_t it;
    it.op     = OP_LOAD;
    it.column = 8'($urandom);
    it.row    = 8'($urandom);
    it.slot   = slot;
    it.box_w  = w;
    it.box_h  = h;
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  task automatic queue_cell(input logic [7:0] column, input logic [7:0] row);
    grid_item_t it;
    it.op     = OP_CELL;
    it.column = column;
    it.row    = row;
    it.slot   = 3'($urandom);
    it.box_w  = 16'($urandom);
    it.box_h  = 16'($urandom);
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(16, 4800));
    endcase
  endfunction

  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly plausible image geometry; a few phases go to the register extremes.
  function automatic abg_cfg_t phase_config(int p);
    abg_cfg_t c;
    c.cell_offset    = 8'($urandom_range(0, 255));
    c.step_x         = 16'($urandom_range(256, 8192));
    c.step_y         = 16'($urandom_range(256, 8192));
    c.inv_width      = 24'($urandom_range(20000, 200000));
    c.inv_height     = 24'($urandom_range(20000, 200000));
    c.clip_enable    = 1'($urandom_range(0, 1));
    c.boxes_per_cell = 4'($urandom_range(1, 8));
    case (p)
      0: begin
        c.cell_offset    = 8'h00;
        c.step_x         = 16'h0000;
        c.step_y         = 16'hFFFF;
        c.inv_width      = 24'hFFFFFF;
        c.inv_height     = 24'h000000;
        c.clip_enable    = 1'b0;
        c.boxes_per_cell = 4'd8;
      end
      1: begin
        // More entries per cell than the table holds: the count saturates.
        c.cell_offset    = 8'hFF;
        c.step_x         = 16'hFFFF;
        c.step_y         = 16'h0000;
        c.inv_width      = 24'h000000;
        c.inv_height     = 24'hFFFFFF;
        c.clip_enable    = 1'b1;
        c.boxes_per_cell = 4'd15;
      end
      2: c.boxes_per_cell = 4'd0;  // Cells yield no box at all.
      STALL_PHASE: c.boxes_per_cell = 4'd8;
      4: begin
        c.step_x     = 16'($urandom);
        c.step_y     = 16'($urandom);
        c.inv_width  = 24'($urandom);
        c.inv_height = 24'($urandom);
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic queue_random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) queue_load(3'($urandom), pick_size(), pick_size());
      else queue_cell(pick_coord(), pick_coord());
    end
  endtask

  task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
                                 input logic [COORD_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [COORD_W-1:0] got,
                             input logic [COORD_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Sender: offers queued items, with short random gaps between them.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_anchor_boxes(offered_item);
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0 && !no_idle && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 2);
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offered_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= offered_item.op;
          s_axis_tdata  <= IN_DATA_W'({offered_item.box_h, offered_item.box_w,
                                       offered_item.slot, offered_item.row,
                                       offered_item.column});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random short stalls, plus one long hold-off that backs the block up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap   = 0;
      stall_left = 0;
    end else if (long_stall_armed && !long_stall_done) begin
      long_stall_done = 1'b1;
      stall_left      = LONG_STALL_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Checker: each box against the oldest expectation, field by field.
  always @(posedge clk_i) begin
    anchor_box_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_boxes.size() == 0) begin
        report_mismatch("unexpected box", COORD_W'(m_axis_tdata[2:0]), '0);
      end else begin
        want = expected_boxes.pop_front();
        check_field("box_index",   COORD_W'(m_axis_tdata[2:0]), COORD_W'(want.index));
        check_field("x_min",       m_axis_tdata[20:3],     want.x_min);
        check_field("y_min",       m_axis_tdata[38:21],    want.y_min);
        check_field("x_max",       m_axis_tdata[56:39],    want.x_max);
        check_field("y_max",       m_axis_tdata[74:57],    want.y_max);
        check_field("x_center",    m_axis_tdata[92:75],    want.x_center);
        check_field("y_center",    m_axis_tdata[110:93],   want.y_center);
        check_field("norm_width",  m_axis_tdata[128:111],  want.norm_w);
        check_field("norm_height", m_axis_tdata[146:129],  want.norm_h);
        check_field("last_box",    COORD_W'(m_axis_tlast), COORD_W'(want.last));
      end
    end
  end

  // Watchdog: ends the run when no channel has moved anything for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** anchor_box_generator_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    abg_cfg_t c;
    shadow_cfg.cell_offset    = RST_CELL_OFFSET;
    shadow_cfg.step_x         = RST_STEP;
    shadow_cfg.step_y         = RST_STEP;
    shadow_cfg.inv_width      = RST_INV_IMG;
    shadow_cfg.inv_height     = RST_INV_IMG;
    shadow_cfg.clip_enable    = 1'b0;
    shadow_cfg.boxes_per_cell = RST_BOXES_PER_CELL;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill every table entry before any cell reads it, then cells at the
    // grid corners and one inner cell, with all eight entries in use.
    c = shadow_cfg;
    c.boxes_per_cell = 4'd8;
    program_config(c);
    queue_load(3'd0, 16'h0000, 16'h0000);
    queue_load(3'd1, 16'hFFFF, 16'hFFFF);
    queue_load(3'd2, 16'd480, 16'd960);
    queue_load(3'd3, 16'd1, 16'd1);
    queue_load(3'd4, 16'hFFFF, 16'h0000);
    queue_load(3'd5, 16'h0000, 16'hFFFF);
    queue_load(3'd6, 16'd1600, 16'd800);
    queue_load(3'd7, 16'd3200, 16'd3200);
    queue_cell(8'd0, 8'd0);
    queue_cell(8'd255, 8'd255);
    queue_cell(8'd0, 8'd255);
    queue_cell(8'd255, 8'd0);
    queue_cell(8'd10, 8'd20);
    wait_for_drain();

    // Corner and inner cells with clipping to the unit range, and a table rewrite.
    c.clip_enable = 1'b1;
    program_config(c);
    queue_cell(8'd0, 8'd0);
    queue_cell(8'd255, 8'd255);
    queue_cell(8'd128, 8'd3);
    queue_load(3'd3, 16'd32768, 16'd12345);
    queue_cell(8'd7, 8'd7);
    wait_for_drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_config(phase_config(p));
      if (p == STALL_PHASE) long_stall_armed = 1'b1;
      if (p == RANDOM_PHASES - 1) no_idle = 1'b1;
      queue_random_items(ITEMS_PER_PHASE);
      wait_for_drain();
    end

    if (mismatch_count == 0) begin
      $display("** anchor_box_generator_core: PASSED **");
    end else begin
      $display("** anchor_box_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
